@@ hw/rtl/nbns_pkg.sv @@
package nbns_pkg;

    localparam int NAME_FIELD_MAX_DEF = 32;
    localparam int CHECK_LIMIT        = 30;
    localparam int RESP_FIXED         = 30;
    localparam int NAME_OFFSET        = 13;
    localparam int OWN_CHARS          = 15;

    localparam logic [5:0] POS_ID_HI  = 6'd0;
    localparam logic [5:0] POS_ID_LO  = 6'd1;
    localparam logic [5:0] POS_FLAGS  = 6'd2;
    localparam logic [5:0] POS_QD_HI  = 6'd4;
    localparam logic [5:0] POS_QD_LO  = 6'd5;
    localparam logic [5:0] POS_LEN    = 6'd12;
    localparam logic [5:0] POS_MAX    = 6'd63;

    localparam logic [1:0] CFG_NAME_FIRST = 2'd0;
    localparam logic [1:0] CFG_NAME_LAST  = 2'd1;
    localparam logic [1:0] CFG_IP_ADDR    = 2'd2;

    localparam logic [7:0] RSP_FLAGS_HI = 8'h84;
    localparam logic [7:0] RSP_FLAGS_LO = 8'h80;
    localparam logic [7:0] RR_TYPE_NB   = 8'h20;
    localparam logic [7:0] RR_CLASS_IN  = 8'h01;
    localparam logic [7:0] ANSWER_ONE   = 8'h01;
    localparam logic [7:0] TTL_BYTE_HI  = 8'h01;
    localparam logic [7:0] TTL_BYTE_LO  = 8'h2c;
    localparam logic [7:0] RD_LENGTH    = 8'h06;
    localparam logic [7:0] LETTER_A     = 8'h41;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NULL    = 8'h00;

    typedef logic [7:0] byte_t;

    function automatic byte_t header_byte(input logic [3:0] idx, input logic [15:0] id);
        byte_t b;
        case (idx)
            4'd0:    b = id[15:8];
            4'd1:    b = id[7:0];
            4'd2:    b = RSP_FLAGS_HI;
            4'd3:    b = RSP_FLAGS_LO;
            4'd7:    b = ANSWER_ONE;
            default: b = CHAR_NULL;
        endcase
        return b;
    endfunction

    function automatic byte_t trailer_byte(input logic [4:0] idx, input logic [31:0] ip);
        byte_t b;
        case (idx)
            5'd2:    b = RR_TYPE_NB;
            5'd4:    b = RR_CLASS_IN;
            5'd7:    b = TTL_BYTE_HI;
            5'd8:    b = TTL_BYTE_LO;
            5'd10:   b = RD_LENGTH;
            5'd13:   b = ip[31:24];
            5'd14:   b = ip[23:16];
            5'd15:   b = ip[15:8];
            5'd16:   b = ip[7:0];
            default: b = CHAR_NULL;
        endcase
        return b;
    endfunction

    function automatic byte_t to_lower(input byte_t c);
        byte_t r;
        if (c >= 8'h41 && c <= 8'h5a) begin
            r = c + 8'h20;
        end else begin
            r = c;
        end
        return r;
    endfunction

    function automatic logic is_lower_letter(input byte_t c);
        return (c >= 8'h61) && (c <= 8'h7a);
    endfunction

endpackage

@@ hw/rtl/netbios_name_query_responder.sv @@
// NetBIOS name service query responder
//
// s_ channel: one UDP payload byte per transaction (s_rx_byte), s_end_of_packet
// on the final byte. m_ channel: bytes of the positive name query response,
// m_last_byte on its final byte. cfg_ channel: register writes, always ready
// (index 0: name chars 0..7, 1: name chars 8..14, 2: IPv4 address).
//
// Input bytes are taken at one per cycle while s_ready is high. A matching
// packet yields 30 + name length response bytes (at most 62) via the sequencer,
// read stage and output register, one per cycle while m_ready is high.
// The encoded name sits in a two-bank name memory: one bank fills from the
// incoming packet while the other is read out for the response, so only a
// final byte arriving while a response is still being read out waits.
// A stall on m_ holds the output register and the read pipeline in place.
// Reset clears the packet state, the configuration and the response sequencer;
// the name memory is not cleared since every entry read was written first.
module netbios_name_query_responder #(
    parameter int NAME_FIELD_MAX = nbns_pkg::NAME_FIELD_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_packet,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_tx_byte,
    output logic        m_last_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import nbns_pkg::*;

    localparam int AW    = (NAME_FIELD_MAX > 1) ? $clog2(NAME_FIELD_MAX) : 1;
    localparam int LW    = $clog2(NAME_FIELD_MAX + 1);
    localparam int TW    = $clog2(RESP_FIXED + NAME_FIELD_MAX);
    localparam int DEPTH = 2 ** (AW + 1);

    // configuration
    logic [63:0] name_first_reg;
    logic [55:0] name_last_reg;
    logic [31:0] ip_reg;

    // receive side
    logic [5:0]    pos_reg, pos_next;
    logic [15:0]   txid_reg, txid_next;
    logic          rej_reg, rej_next;
    logic          qd_reg, qd_next;
    logic [LW-1:0] len_reg, len_next;
    logic          term_reg, term_next;
    logic          cmp_done_reg, cmp_done_next;
    logic          cmp_ok_reg, cmp_ok_next;
    logic [7:0]    first_reg, first_next;
    logic          rx_bank_reg, rx_bank_next;

    // response side
    logic          tx_active_reg;
    logic [TW-1:0] tx_idx_reg;
    logic [LW-1:0] tx_len_reg;
    logic [15:0]   tx_id_reg;
    logic          tx_bank_reg;
    logic          s1_valid_reg, s1_name_reg, s1_last_reg;
    logic [7:0]    s1_byte_reg;
    logic [7:0]    rd_reg;
    logic          m_valid_reg, m_last_reg;
    logic [7:0]    m_byte_reg;

    logic [7:0] name_mem [DEPTH];

    logic          s_fire;
    logic          emit_start;
    logic          adv;
    logic [5:0]    idx;
    logic [5:0]    len6;
    logic          in_name, store, term_byte, pair_now;
    logic [7:0]    pair_first, pair_second, dec_hi, dec_lo, got, got_l, ours;
    logic [119:0]  own_name_w;
    logic [7:0]    own_char [16];
    logic          mem_we;
    logic [AW:0]   wr_addr, rd_addr;
    logic [TW-1:0] tx_last_idx, name_end;
    logic          tx_in_name, tx_is_last;
    logic [7:0]    tx_const;

    assign cfg_ready = 1'b1;
    assign s_ready   = !(tx_active_reg && s_end_of_packet);
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_first_reg <= '0;
            name_last_reg  <= '0;
            ip_reg         <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_NAME_FIRST: name_first_reg <= cfg_data;
                CFG_NAME_LAST:  name_last_reg  <= cfg_data[55:0];
                CFG_IP_ADDR:    ip_reg         <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign own_name_w = {name_first_reg, name_last_reg};

    always_comb begin
        for (int i = 0; i < OWN_CHARS; i++) begin
            own_char[i] = own_name_w[119 - 8 * i -: 8];
        end
        own_char[15] = CHAR_NULL;
    end

    // incremental name compare, per letter pair on its second or final name byte
    assign idx         = pos_reg - 6'(NAME_OFFSET);
    assign len6        = 6'(len_reg);
    assign in_name     = !rej_reg && (pos_reg > POS_LEN);
    assign store       = in_name && (idx < len6);
    assign term_byte   = in_name && (idx == len6);
    assign pair_now    = store && (idx[0] || (idx == len6 - 6'd1))
                         && ({idx[5:1], 1'b0} < 6'(CHECK_LIMIT));
    assign pair_first  = idx[0] ? first_reg : s_rx_byte;
    assign pair_second = idx[0] ? s_rx_byte : LETTER_A;
    assign dec_hi      = pair_first - LETTER_A;
    assign dec_lo      = pair_second - LETTER_A;
    assign got         = {dec_hi[3:0], 4'b0000} + dec_lo;
    assign got_l       = to_lower(got);
    assign ours        = to_lower(own_char[idx[4:1]]);

    always_comb begin
        pos_next      = pos_reg;
        txid_next     = txid_reg;
        rej_next      = rej_reg;
        qd_next       = qd_reg;
        len_next      = len_reg;
        term_next     = term_reg;
        cmp_done_next = cmp_done_reg;
        cmp_ok_next   = cmp_ok_reg;
        first_next    = first_reg;
        rx_bank_next  = rx_bank_reg;
        emit_start    = 1'b0;
        if (s_fire) begin
            if (!rej_reg) begin
                case (pos_reg)
                    POS_ID_HI: txid_next[15:8] = s_rx_byte;
                    POS_ID_LO: txid_next[7:0]  = s_rx_byte;
                    POS_FLAGS: begin
                        if (s_rx_byte[7]) begin
                            rej_next = 1'b1;
                        end
                    end
                    POS_QD_HI, POS_QD_LO: begin
                        if (s_rx_byte != CHAR_NULL) begin
                            qd_next = 1'b1;
                        end
                    end
                    POS_LEN: begin
                        if (!qd_reg || (s_rx_byte > 8'(NAME_FIELD_MAX))) begin
                            rej_next = 1'b1;
                        end else begin
                            len_next = LW'(s_rx_byte);
                        end
                    end
                    default: ;
                endcase
            end
            if (store && !idx[0]) begin
                first_next = s_rx_byte;
            end
            if (pair_now && !cmp_done_reg) begin
                if ((got_l == CHAR_SPACE) && !is_lower_letter(ours)) begin
                    cmp_done_next = 1'b0;
                end else if (got_l == CHAR_NULL) begin
                    cmp_done_next = 1'b1;
                    cmp_ok_next   = (ours == CHAR_NULL);
                end else if (got_l != ours) begin
                    cmp_done_next = 1'b1;
                    cmp_ok_next   = 1'b0;
                end
            end
            if (term_byte) begin
                if (s_rx_byte != CHAR_NULL) begin
                    rej_next = 1'b1;
                end else begin
                    term_next = 1'b1;
                end
            end
            if (pos_reg != POS_MAX) begin
                pos_next = pos_reg + 6'd1;
            end
            if (s_end_of_packet) begin
                emit_start    = !rej_next && term_next && (!cmp_done_next || cmp_ok_next);
                pos_next      = '0;
                rej_next      = 1'b0;
                qd_next       = 1'b0;
                len_next      = '0;
                term_next     = 1'b0;
                cmp_done_next = 1'b0;
                cmp_ok_next   = 1'b0;
                if (emit_start) begin
                    rx_bank_next = !rx_bank_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            txid_reg     <= '0;
            rej_reg      <= 1'b0;
            qd_reg       <= 1'b0;
            len_reg      <= '0;
            term_reg     <= 1'b0;
            cmp_done_reg <= 1'b0;
            cmp_ok_reg   <= 1'b0;
            rx_bank_reg  <= 1'b0;
        end else begin
            pos_reg      <= pos_next;
            txid_reg     <= txid_next;
            rej_reg      <= rej_next;
            qd_reg       <= qd_next;
            len_reg      <= len_next;
            term_reg     <= term_next;
            cmp_done_reg <= cmp_done_next;
            cmp_ok_reg   <= cmp_ok_next;
            rx_bank_reg  <= rx_bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg <= first_next;
    end

    // name memory, one bank per packet in flight
    assign mem_we  = s_fire && store;
    assign wr_addr = {rx_bank_reg, idx[AW-1:0]};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            name_mem[wr_addr] <= s_rx_byte;
        end
    end

    // response sequencer, read stage and output register share one enable
    assign adv         = !m_valid_reg || m_ready;
    assign tx_last_idx = TW'(RESP_FIXED - 1) + TW'(tx_len_reg);
    assign name_end    = TW'(NAME_OFFSET) + TW'(tx_len_reg);
    assign tx_in_name  = (tx_idx_reg >= TW'(NAME_OFFSET)) && (tx_idx_reg < name_end);
    assign tx_is_last  = (tx_idx_reg == tx_last_idx);
    assign rd_addr     = {tx_bank_reg, AW'(tx_idx_reg - TW'(NAME_OFFSET))};

    always_comb begin
        if (tx_idx_reg < TW'(NAME_OFFSET - 1)) begin
            tx_const = header_byte(tx_idx_reg[3:0], tx_id_reg);
        end else if (tx_idx_reg == TW'(NAME_OFFSET - 1)) begin
            tx_const = 8'(tx_len_reg);
        end else begin
            tx_const = trailer_byte(5'(tx_idx_reg - name_end), ip_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_active_reg <= 1'b0;
            tx_idx_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (emit_start) begin
                tx_active_reg <= 1'b1;
                tx_idx_reg    <= '0;
            end else if (adv && tx_active_reg) begin
                tx_idx_reg <= tx_idx_reg + TW'(1);
                if (tx_is_last) begin
                    tx_active_reg <= 1'b0;
                end
            end
            if (adv) begin
                s1_valid_reg <= tx_active_reg;
                m_valid_reg  <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_start) begin
            tx_len_reg  <= len_reg;
            tx_id_reg   <= txid_next;
            tx_bank_reg <= rx_bank_reg;
        end
        if (adv) begin
            rd_reg      <= name_mem[rd_addr];
            s1_name_reg <= tx_in_name;
            s1_byte_reg <= tx_const;
            s1_last_reg <= tx_is_last;
            m_byte_reg  <= s1_name_reg ? rd_reg : s1_byte_reg;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_tx_byte   = m_byte_reg;
    assign m_last_byte = m_last_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_start |-> !tx_active_reg)
        else $error("response started while another is being read out");

    a_bank_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && tx_active_reg) |-> (rx_bank_reg != tx_bank_reg))
        else $error("name write hits the bank being read out");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tx_active_reg |-> (tx_idx_reg <= tx_last_idx))
        else $error("response index past the end");

    a_term_rej: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rej_reg && term_reg))
        else $error("packet both rejected and terminated");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (tx_active_reg && tx_is_last && adv) |=> !tx_active_reg)
        else $error("sequencer still active after last byte");

endmodule

@@ tb/tb_netbios_name_query_responder.sv @@
`timescale 1ns / 1ps

module tb_netbios_name_query_responder;
    import nbns_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_BYTES = 140;
    localparam int SETTLE       = 8;

    localparam logic [1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } tx_item_t;

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte       = 8'h00;
    logic        s_end_of_packet = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [7:0]  m_tx_byte;
    logic        m_last_byte;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index       = 2'd0;
    logic [63:0] cfg_data        = 64'd0;

    // configuration copy
    logic [63:0] name_first = '0;
    logic [55:0] name_last  = '0;
    logic [31:0] own_ip     = '0;

    // per-packet receive state
    logic [5:0]  rx_pos     = '0;
    logic [15:0] rx_id      = '0;
    logic        rx_reject  = 1'b0;
    logic        rx_qd_nz   = 1'b0;
    logic [5:0]  rx_len     = '0;
    byte_t       rx_name [NAME_FIELD_MAX_DEF];
    logic        rx_term_ok = 1'b0;
    logic        rx_decided = 1'b0;
    logic        rx_match   = 1'b0;

    tx_item_t    tx_expected [$];
    int          errors      = 0;
    int          cycle_count = 0;
    bit          no_stall    = 1'b0;

    netbios_name_query_responder u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .s_end_of_packet (s_end_of_packet),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_byte       (m_tx_byte),
        .m_last_byte     (m_last_byte),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= no_stall || ($urandom_range(99) >= 6);
    end

    always @(posedge aclk) begin
        tx_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tx_expected.size() == 0) begin
                if (errors < 10) begin
                    $display("unexpected tx transaction: byte %02h last %0b",
                             m_tx_byte, m_last_byte);
                end
                errors++;
            end else begin
                want = tx_expected.pop_front();
                if (m_tx_byte !== want.data || m_last_byte !== want.last) begin
                    if (errors < 10) begin
                        $display("tx mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                                 want.data, want.last, m_tx_byte, m_last_byte);
                    end
                    errors++;
                end
            end
        end
    end

    function automatic byte_t own_char(int i);
        if (i < 8) begin
            return name_first[63 - 8 * i -: 8];
        end
        if (i < OWN_CHARS) begin
            return name_last[55 - 8 * (i - 8) -: 8];
        end
        return CHAR_NULL;
    endfunction

    function automatic byte_t fold_case(byte_t c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'h20 : c;
    endfunction

    function automatic bit query_name_matches();
        int    n;
        byte_t hi;
        byte_t lo;
        byte_t got;
        byte_t ours;
        n = (rx_len < CHECK_LIMIT) ? rx_len : CHECK_LIMIT;
        for (int c = 0; c < n; c += 2) begin
            hi = rx_name[c];
            lo = (c + 1 < rx_len) ? rx_name[c + 1] : LETTER_A;
            got = ((hi - LETTER_A) << 4) + (lo - LETTER_A);
            got = fold_case(got);
            ours = fold_case(own_char(c / 2));
            if (got == CHAR_SPACE && !(ours >= 8'h61 && ours <= 8'h7a)) begin
                continue;
            end
            if (got == CHAR_NULL) begin
                return ours == CHAR_NULL;
            end
            if (got != ours) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_rx_byte(byte_t b, logic eop);
        int       idx;
        byte_t    frame [$];
        byte_t    head [13];
        byte_t    tail [17];
        tx_item_t item;
        if (!rx_reject) begin
            if (rx_pos == POS_ID_HI) begin
                rx_id[15:8] = b;
            end else if (rx_pos == POS_ID_LO) begin
                rx_id[7:0] = b;
            end else if (rx_pos == POS_FLAGS) begin
                if (b[7]) rx_reject = 1'b1;
            end else if (rx_pos == POS_QD_HI || rx_pos == POS_QD_LO) begin
                if (b != 8'h00) rx_qd_nz = 1'b1;
            end else if (rx_pos == POS_LEN) begin
                if (!rx_qd_nz || b > NAME_FIELD_MAX_DEF) begin
                    rx_reject = 1'b1;
                end else begin
                    rx_len = b[5:0];
                end
            end else if (rx_pos > POS_LEN) begin
                idx = rx_pos - NAME_OFFSET;
                if (idx < rx_len) begin
                    rx_name[idx] = b;
                end else if (idx == rx_len) begin
                    if (b != 8'h00) begin
                        rx_reject = 1'b1;
                    end else begin
                        rx_term_ok = 1'b1;
                        rx_match   = query_name_matches();
                        rx_decided = 1'b1;
                    end
                end
            end
        end
        if (rx_pos != POS_MAX) rx_pos = rx_pos + 6'd1;

        if (eop) begin
            if (!rx_reject && rx_term_ok && rx_decided && rx_match) begin
                head = '{rx_id[15:8], rx_id[7:0], RSP_FLAGS_HI, RSP_FLAGS_LO,
                         CHAR_NULL, CHAR_NULL, CHAR_NULL, ANSWER_ONE,
                         CHAR_NULL, CHAR_NULL, CHAR_NULL, CHAR_NULL, {2'b00, rx_len}};
                tail = '{CHAR_NULL, CHAR_NULL, RR_TYPE_NB, CHAR_NULL, RR_CLASS_IN,
                         CHAR_NULL, CHAR_NULL, TTL_BYTE_HI, TTL_BYTE_LO,
                         CHAR_NULL, RD_LENGTH, CHAR_NULL, CHAR_NULL,
                         own_ip[31:24], own_ip[23:16], own_ip[15:8], own_ip[7:0]};
                foreach (head[i]) frame.push_back(head[i]);
                for (int i = 0; i < rx_len; i++) frame.push_back(rx_name[i]);
                foreach (tail[i]) frame.push_back(tail[i]);
                foreach (frame[i]) begin
                    item.data = frame[i];
                    item.last = (i == frame.size() - 1);
                    tx_expected.push_back(item);
                end
            end
            rx_pos     = '0;
            rx_reject  = 1'b0;
            rx_qd_nz   = 1'b0;
            rx_len     = '0;
            rx_term_ok = 1'b0;
            rx_decided = 1'b0;
            rx_match   = 1'b0;
        end
    endfunction

    task automatic send_byte(input byte_t b, input logic eop);
        @(negedge aclk);
        while (!no_stall && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_rx_byte       <= b;
        s_end_of_packet <= eop;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_rx_byte(b, eop);
    endtask

    task automatic send_packet(input byte_t p [$]);
        foreach (p[i]) send_byte(p[i], i == p.size() - 1);
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tx_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_NAME_FIRST: name_first = data;
            CFG_NAME_LAST:  name_last  = data[55:0];
            CFG_IP_ADDR:    own_ip     = data[31:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void build_query(ref byte_t p [$], input logic [15:0] id,
                                        input byte_t flags, input byte_t qd_lo,
                                        input byte_t len, input string nm, input byte_t pad,
                                        input byte_t term, input int tail);
        byte_t c;
        p = {};
        p.push_back(id[15:8]);
        p.push_back(id[7:0]);
        p.push_back(flags);
        p.push_back(8'h10);
        p.push_back(8'h00);
        p.push_back(qd_lo);
        repeat (6) p.push_back(8'h00);
        p.push_back(len);
        for (int i = 0; i < len; i++) begin
            c = (i / 2 < nm.len()) ? nm[i / 2] : pad;
            p.push_back(LETTER_A + ((i % 2 == 0) ? c[7:4] : c[3:0]));
        end
        p.push_back(term);
        for (int i = 0; i < tail; i++) p.push_back(byte_t'($urandom_range(255)));
    endfunction

    task automatic send_query(input logic [15:0] id, input byte_t flags, input byte_t qd_lo,
                              input byte_t len, input string nm, input byte_t pad,
                              input byte_t term, input int tail, input int cut);
        byte_t p [$];
        build_query(p, id, flags, qd_lo, len, nm, pad, term, tail);
        if (cut > 0) p = p[0:cut-1];
        send_packet(p);
    endtask

    function automatic void make_random_packet(ref byte_t p [$]);
        int    kind;
        int    len;
        int    pick;
        int    spot;
        int    cut;
        byte_t ch;
        byte_t flags;
        bit    letter;
        kind = $urandom_range(99);
        p = {};
        if (kind < 5) begin
            repeat ($urandom_range(70, 1)) p.push_back(byte_t'($urandom_range(255)));
            return;
        end
        flags = byte_t'($urandom_range(127));
        if (kind >= 70 && kind < 75) flags[7] = 1'b1;
        p.push_back(byte_t'($urandom_range(255)));
        p.push_back(byte_t'($urandom_range(255)));
        p.push_back(flags);
        p.push_back(byte_t'($urandom_range(255)));
        if (kind >= 75 && kind < 80) begin
            p.push_back(8'h00);
            p.push_back(8'h00);
        end else if ($urandom_range(3) != 0) begin
            p.push_back(8'h00);
            p.push_back(8'h01);
        end else begin
            p.push_back(byte_t'($urandom_range(255)));
            p.push_back(byte_t'($urandom_range(255, 1)));
        end
        repeat (6) p.push_back(byte_t'($urandom_range(255)));

        pick = $urandom_range(99);
        if (kind >= 80 && kind < 85) begin
            len = $urandom_range(255, 33);
        end else if (pick < 35) begin
            len = 32;
        end else if (pick < 85) begin
            len = $urandom_range(16);
        end else begin
            len = $urandom_range(31, 17);
        end
        p.push_back(byte_t'(len));
        if (len > NAME_FIELD_MAX_DEF) begin
            repeat ($urandom_range(8)) p.push_back(byte_t'($urandom_range(255)));
            return;
        end

        // encode our own name with random case and spaces, optionally one corrupt byte
        spot = (kind >= 50 && kind < 70) ? $urandom_range((len > 0) ? len - 1 : 0) : -1;
        ch = CHAR_NULL;
        for (int i = 0; i < len; i++) begin
            if (i % 2 == 0) begin
                ch = own_char(i / 2);
                letter = (ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a);
                if (letter) begin
                    if ($urandom_range(1)) ch = ch ^ 8'h20;
                end else if ($urandom_range(3) == 0) begin
                    ch = CHAR_SPACE;
                end
            end
            if (i == spot) begin
                p.push_back(byte_t'($urandom_range(255)));
            end else begin
                p.push_back(LETTER_A + ((i % 2 == 0) ? ch[7:4] : ch[3:0]));
            end
        end
        p.push_back((kind >= 85 && kind < 90) ? byte_t'($urandom_range(255, 1)) : CHAR_NULL);
        repeat (($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(4)) begin
            p.push_back(byte_t'($urandom_range(255)));
        end
        if (kind >= 90) begin
            cut = $urandom_range(13 + len, 1);
            p = p[0:cut-1];
        end
    endfunction

    task automatic test_reset_defaults();
        send_query(16'h1234, 8'h01, 8'h01, 8'd8, "", CHAR_NULL, CHAR_NULL, 0, 0);
        send_query(16'h5aa5, 8'h01, 8'h01, 8'd0, "", CHAR_NULL, CHAR_NULL, 0, 0);
        wait_idle();
    endtask

    task automatic test_response_extremes();
        write_reg(CFG_NAME_FIRST, "FILESRV-");
        write_reg(CFG_NAME_LAST, "01     ");
        write_reg(CFG_IP_ADDR, 64'h0000_0000_c0a8_0a17);
        send_query(16'h0000, 8'h01, 8'h01, 8'd0, "", CHAR_SPACE, CHAR_NULL, 0, 0);
        // trailing bytes run past the saturating position counter
        send_query(16'hffff, 8'h01, 8'h01, 8'd32, "filesrv-01", CHAR_SPACE, CHAR_NULL, 20, 0);
        wait_idle();
    endtask

    task automatic test_header_rejects();
        send_query(16'h1111, 8'h81, 8'h01, 8'd4, "FILESRV-01", CHAR_SPACE, CHAR_NULL, 0, 0);
        send_query(16'h2222, 8'h01, 8'h00, 8'd4, "FILESRV-01", CHAR_SPACE, CHAR_NULL, 0, 0);
        send_query(16'h3333, 8'h01, 8'h01, 8'd33, "FILESRV-01", CHAR_SPACE, CHAR_NULL, 0, 14);
        send_query(16'h4444, 8'h01, 8'h01, 8'd4, "FILESRV-01", CHAR_SPACE, 8'h01, 0, 0);
        send_query(16'h5555, 8'h01, 8'h01, 8'd32, "FILESRV-01", CHAR_SPACE, CHAR_NULL, 0, 20);
        wait_idle();
    endtask

    task automatic test_name_compare();
        // space against a non-letter, plain mismatch, odd lengths
        send_query(16'h6001, 8'h01, 8'h01, 8'd16, "FILESRV 01", CHAR_SPACE, CHAR_NULL, 0, 0);
        send_query(16'h6002, 8'h01, 8'h01, 8'd20, "FILESRV-02", CHAR_SPACE, CHAR_NULL, 0, 0);
        send_query(16'h6003, 8'h01, 8'h01, 8'd15, "FILESRV-0", CHAR_SPACE, CHAR_NULL, 1, 0);
        send_query(16'h6004, 8'h01, 8'h01, 8'd7, "FILE", CHAR_SPACE, CHAR_NULL, 1, 0);
        wait_idle();
        write_reg(CFG_NAME_FIRST, {"HOP", 40'h0});
        write_reg(CFG_NAME_LAST, 64'h0);
        write_reg(CFG_IP_ADDR, 64'hffff_ffff_ffff_ffff);
        // null in the query ends the name
        send_query(16'h7001, 8'h01, 8'h01, 8'd5, "HOP", CHAR_NULL, CHAR_NULL, 0, 0);
        send_query(16'h7002, 8'h01, 8'h01, 8'd8, "HOP", CHAR_NULL, CHAR_NULL, 0, 0);
        send_query(16'h7003, 8'h01, 8'h01, 8'd8, "HO", CHAR_NULL, CHAR_NULL, 0, 0);
        send_query(16'h7004, 8'h01, 8'h01, 8'd8, "hop", CHAR_SPACE, CHAR_NULL, 0, 0);
        wait_idle();
    endtask

    task automatic test_extreme_config();
        write_reg(CFG_NAME_FIRST, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_NAME_LAST, 64'hffff_ffff_ffff_ffff);
        write_reg(CFG_IP_ADDR, 64'hffff_ffff_0000_0000);
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        send_query(16'h8001, 8'h7f, 8'hff, 8'd32, "", 8'hff, CHAR_NULL, 0, 0);
        send_query(16'h8002, 8'h01, 8'h01, 8'd31, "", 8'hff, CHAR_NULL, 0, 0);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        byte_t pkt [$];
        int    sent;
        bit    paused;
        sent   = 0;
        paused = 1'b0;
        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    write_reg(CFG_NAME_FIRST, "WORKGROU");
                    write_reg(CFG_NAME_LAST, "P-PC07 ");
                    write_reg(CFG_IP_ADDR, {$urandom, $urandom});
                end
                1: begin
                    write_reg(CFG_NAME_FIRST, {$urandom, $urandom});
                    write_reg(CFG_NAME_LAST, {$urandom, $urandom});
                    write_reg(CFG_IP_ADDR, {$urandom, $urandom});
                end
                2: begin
                    write_reg(CFG_NAME_FIRST, {"nas", 40'h0});
                    write_reg(CFG_NAME_LAST, 64'h0);
                    write_reg(CFG_IP_ADDR, 64'hffff_ffff);
                end
                default: begin
                    write_reg(CFG_NAME_FIRST, 64'h0);
                    write_reg(CFG_NAME_LAST, 64'h0);
                    write_reg(CFG_IP_ADDR, 64'h0);
                end
            endcase
            no_stall = (ph == 1);
            while (sent < RANDOM_BYTES * (ph + 1) / 4) begin
                make_random_packet(pkt);
                send_packet(pkt);
                sent += pkt.size();
                if (ph == 0 && !paused && sent >= RANDOM_BYTES / 8) begin
                    wait_idle();
                    paused = 1'b1;
                end
            end
        end
        wait_idle();
        no_stall = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_response_extremes();
        test_header_rejects();
        test_name_compare();
        test_extreme_config();
        test_random_traffic();

        wait_idle();
        if (errors == 0 && tx_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/nbns_pkg.sv
hw/rtl/netbios_name_query_responder.sv
tb/tb_netbios_name_query_responder.sv
